@@ rtl/rbt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row block transposition cipher - shared definitions
// Character codes, configuration register indexes, row tags and the state
// encoding of the emission sequencer.
// ----------------------------------------------------------------------------
package rbt_pkg;

	localparam int CHAR_W     = 8;
	localparam int KEY_LEN_W  = 5;
	localparam int KEY_REG_W  = 64;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE       = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW    = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH   = CFG_IDX_W'(3);

	localparam logic [CHAR_W-1:0] LOWER_A     = 8'h61;
	localparam logic [CHAR_W-1:0] LOWER_Z     = 8'h7A;
	localparam logic [CHAR_W-1:0] UPPER_A     = 8'h41;
	localparam logic [CHAR_W-1:0] UPPER_Z     = 8'h5A;
	localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;
	localparam logic [CHAR_W-1:0] PAD_CHAR    = 8'h58;

	typedef struct packed {
		logic valid;
		logic final_row;
	} row_tag_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_SCAN,
		B_EMIT
	} back_state_t;

endpackage

@@ rtl/rbt_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row block transposition cipher - front end
// Accepts message bytes, drops non-letters, raises case and gathers letters
// into the current row slot; hands a complete row on to the row queue.
// ----------------------------------------------------------------------------
module rbt_front #(
	parameter int MAX_KEY_CHARS = 16,
	localparam int IDX_W = $clog2(MAX_KEY_CHARS),
	localparam int CNT_W = $clog2(MAX_KEY_CHARS + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic [rbt_pkg::CHAR_W-1:0] char_in,
	input  logic                      message_last,
	input  logic [CNT_W-1:0]          len,
	input  logic                      slot_full,
	output logic                      wr_en,
	output logic [IDX_W-1:0]          wr_idx,
	output logic [rbt_pkg::CHAR_W-1:0] wr_char,
	output rbt_pkg::row_tag_t         row_push,
	output logic [CNT_W-1:0]          push_fill
);

	logic [CNT_W-1:0]           fill_q;
	logic [CNT_W-1:0]           fill_next;
	logic [rbt_pkg::CHAR_W-1:0] upper;
	logic                       letter;
	logic                       accept;
	logic                       complete;

	assign full   = slot_full;
	assign accept = push & ~slot_full;

	always_comb begin
		if (char_in >= rbt_pkg::LOWER_A && char_in <= rbt_pkg::LOWER_Z) begin
			upper = char_in - rbt_pkg::CASE_OFFSET;
		end else begin
			upper = char_in;
		end
	end

	assign letter    = (upper >= rbt_pkg::UPPER_A) && (upper <= rbt_pkg::UPPER_Z);
	assign fill_next = fill_q + CNT_W'(letter);
	assign complete  = (fill_next >= len) || (message_last && (fill_next != '0));

	assign wr_en   = accept && letter && (fill_q < CNT_W'(MAX_KEY_CHARS));
	assign wr_idx  = fill_q[IDX_W-1:0];
	assign wr_char = upper;

	assign row_push.valid     = accept && complete;
	assign row_push.final_row = message_last;
	assign push_fill          = fill_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			if (complete) begin
				fill_q <= '0;
			end else begin
				fill_q <= fill_next;
			end
		end
	end

endmodule

@@ rtl/rbt_rowq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row block transposition cipher - row queue
// Two row slots used in turn: the front fills one while the back drains the
// other. Each slot keeps its letters, its letter count and a final flag.
// ----------------------------------------------------------------------------
module rbt_rowq #(
	parameter int MAX_KEY_CHARS = 16,
	localparam int IDX_W = $clog2(MAX_KEY_CHARS),
	localparam int CNT_W = $clog2(MAX_KEY_CHARS + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [IDX_W-1:0]           wr_idx,
	input  logic [rbt_pkg::CHAR_W-1:0] wr_char,
	input  rbt_pkg::row_tag_t          row_push,
	input  logic [CNT_W-1:0]           push_fill,
	output logic                       slot_full,
	output rbt_pkg::row_tag_t          head,
	output logic [CNT_W-1:0]           head_fill,
	input  logic [IDX_W-1:0]           rd_idx,
	output logic [rbt_pkg::CHAR_W-1:0] rd_char,
	input  logic                       release_row
);

	logic                       wr_ptr_q;
	logic                       rd_ptr_q;
	logic [1:0]                 busy_q;
	logic [1:0]                 busy_next;
	logic [1:0]                 final_q;
	logic [CNT_W-1:0]           fill_q [2];
	logic [rbt_pkg::CHAR_W-1:0] data_q [2][MAX_KEY_CHARS];

	assign slot_full      = busy_q[wr_ptr_q];
	assign head.valid     = busy_q[rd_ptr_q];
	assign head.final_row = final_q[rd_ptr_q];
	assign head_fill      = fill_q[rd_ptr_q];
	assign rd_char        = data_q[rd_ptr_q][rd_idx];

	always_comb begin
		busy_next = busy_q;
		if (row_push.valid) begin
			busy_next[wr_ptr_q] = 1'b1;
		end
		if (release_row) begin
			busy_next[rd_ptr_q] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			busy_q   <= '0;
		end else begin
			busy_q <= busy_next;
			if (row_push.valid) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (release_row) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			data_q[wr_ptr_q][wr_idx] <= wr_char;
		end
		if (row_push.valid) begin
			final_q[wr_ptr_q] <= row_push.final_row;
			fill_q[wr_ptr_q]  <= push_fill;
		end
	end

endmodule

@@ rtl/rbt_rank.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row block transposition cipher - rank table
// Builds the column source table from the key, one key position a cycle,
// after reset and after every register write. Encrypt stores rank(p) at p,
// decrypt stores p at rank(p).
// ----------------------------------------------------------------------------
module rbt_rank #(
	parameter int MAX_KEY_CHARS = 16,
	localparam int IDX_W = $clog2(MAX_KEY_CHARS),
	localparam int CNT_W = $clog2(MAX_KEY_CHARS + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           rebuild,
	input  logic                           mode,
	input  logic [CNT_W-1:0]               len,
	input  logic [2*rbt_pkg::KEY_REG_W-1:0] key_chars,
	input  logic [IDX_W-1:0]               rd_idx,
	output logic [IDX_W-1:0]               rd_src,
	output logic                           ready
);

	logic                       ready_q;
	logic [IDX_W-1:0]           p_q;
	logic [IDX_W-1:0]           src_q [MAX_KEY_CHARS];
	logic [rbt_pkg::CHAR_W-1:0] key_b [MAX_KEY_CHARS];
	logic [rbt_pkg::CHAR_W-1:0] kp;
	logic [CNT_W-1:0]           rank;
	logic [IDX_W-1:0]           last_idx;

	for (genvar g = 0; g < MAX_KEY_CHARS; g++) begin : g_key
		assign key_b[g] = key_chars[g*rbt_pkg::CHAR_W +: rbt_pkg::CHAR_W];
	end

	assign kp       = key_b[p_q];
	assign last_idx = IDX_W'(len - CNT_W'(1));
	assign ready    = ready_q;
	assign rd_src   = src_q[rd_idx];

	always_comb begin
		rank = '0;
		for (int i = 0; i < MAX_KEY_CHARS; i++) begin
			if (CNT_W'(i) < len &&
			    (key_b[i] < kp || (key_b[i] == kp && IDX_W'(i) < p_q))) begin
				rank = rank + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
			p_q     <= '0;
		end else if (rebuild) begin
			ready_q <= 1'b0;
			p_q     <= '0;
		end else if (!ready_q) begin
			if (p_q == last_idx) begin
				ready_q <= 1'b1;
			end else begin
				p_q <= p_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!ready_q && !rebuild) begin
			if (mode) begin
				src_q[rank[IDX_W-1:0]] <= p_q;
			end else begin
				src_q[p_q] <= rank[IDX_W-1:0];
			end
		end
	end

endmodule

@@ rtl/rbt_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row block transposition cipher - back end
// Drains queued rows in key order through an output register, padding short
// rows with X and trimming trailing pad from the final row in decrypt mode.
// ----------------------------------------------------------------------------
module rbt_back #(
	parameter int MAX_KEY_CHARS = 16,
	localparam int IDX_W = $clog2(MAX_KEY_CHARS),
	localparam int CNT_W = $clog2(MAX_KEY_CHARS + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       mode,
	input  logic [CNT_W-1:0]           len,
	input  rbt_pkg::row_tag_t          head,
	input  logic [CNT_W-1:0]           head_fill,
	input  logic [rbt_pkg::CHAR_W-1:0] rd_char,
	output logic [IDX_W-1:0]           rd_idx,
	output logic                       release_row,
	input  logic                       tbl_ready,
	output logic [IDX_W-1:0]           tbl_idx,
	input  logic [IDX_W-1:0]           tbl_src,
	output logic                       empty,
	input  logic                       pop,
	output logic [rbt_pkg::CHAR_W-1:0] char_out,
	output logic                       row_end,
	output logic                       message_end
);

	rbt_pkg::back_state_t       state_q;
	rbt_pkg::back_state_t       state_next;
	logic [IDX_W-1:0]           k_q;
	logic [IDX_W-1:0]           last_q;
	logic [IDX_W-1:0]           len_last;
	logic [rbt_pkg::CHAR_W-1:0] cur_char;
	logic                       is_pad;
	logic                       at_last;
	logic                       out_free;
	logic                       load_out;
	logic                       start;
	logic                       out_valid_q;
	logic [rbt_pkg::CHAR_W-1:0] char_q;
	logic                       row_end_q;
	logic                       msg_end_q;

	assign len_last = IDX_W'(len - CNT_W'(1));
	assign tbl_idx  = k_q;
	assign rd_idx   = tbl_src;
	assign cur_char = (CNT_W'(tbl_src) < head_fill) ? rd_char : rbt_pkg::PAD_CHAR;
	assign is_pad   = (cur_char == rbt_pkg::PAD_CHAR);
	assign at_last  = (k_q == last_q);
	assign out_free = !out_valid_q || pop;
	assign start    = head.valid && tbl_ready;

	always_comb begin
		state_next = state_q;
		case (state_q)
			rbt_pkg::B_IDLE: begin
				if (start) begin
					state_next = (mode && head.final_row) ? rbt_pkg::B_SCAN : rbt_pkg::B_EMIT;
				end
			end
			rbt_pkg::B_SCAN: begin
				if (!is_pad) begin
					state_next = rbt_pkg::B_EMIT;
				end else if (k_q == '0) begin
					state_next = rbt_pkg::B_IDLE;
				end
			end
			rbt_pkg::B_EMIT: begin
				if (out_free && at_last) begin
					state_next = rbt_pkg::B_IDLE;
				end
			end
			default: state_next = rbt_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		release_row = 1'b0;
		load_out    = 1'b0;
		case (state_q)
			rbt_pkg::B_SCAN: begin
				release_row = is_pad && (k_q == '0);
			end
			rbt_pkg::B_EMIT: begin
				load_out    = out_free;
				release_row = out_free && at_last;
			end
			default: begin
				release_row = 1'b0;
				load_out    = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rbt_pkg::B_IDLE;
			k_q     <= '0;
			last_q  <= '0;
		end else begin
			state_q <= state_next;
			case (state_q)
				rbt_pkg::B_IDLE: begin
					if (start) begin
						if (mode && head.final_row) begin
							k_q <= len_last;
						end else begin
							k_q    <= '0;
							last_q <= len_last;
						end
					end
				end
				rbt_pkg::B_SCAN: begin
					if (!is_pad) begin
						last_q <= k_q;
						k_q    <= '0;
					end else if (k_q != '0) begin
						k_q <= k_q - IDX_W'(1);
					end
				end
				rbt_pkg::B_EMIT: begin
					if (out_free && !at_last) begin
						k_q <= k_q + IDX_W'(1);
					end
				end
				default: k_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			char_q    <= cur_char;
			row_end_q <= at_last;
			msg_end_q <= at_last && head.final_row;
		end
	end

	assign empty       = !out_valid_q;
	assign char_out    = char_q;
	assign row_end     = row_end_q;
	assign message_end = msg_end_q;

	a_busy_has_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rbt_pkg::B_SCAN || state_q == rbt_pkg::B_EMIT) |-> head.valid && tbl_ready)
		else $error("row drain running without a queued row or rank table");

	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rbt_pkg::B_EMIT) |-> (k_q <= last_q))
		else $error("emit index passed the last kept column");

	a_release_idle: assert property (@(posedge clk) disable iff (!arst_n)
		release_row |=> (state_q == rbt_pkg::B_IDLE))
		else $error("sequencer not idle after releasing a row");

endmodule

@@ rtl/row_block_transposition_cipher_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row block transposition cipher unit
// Message bytes enter through push/full and leave as permuted letters through
// empty/pop. An item is taken when push is high and full low; a result is
// taken when pop is high and empty low. Non-letters are dropped, letters are
// raised to upper case and gathered into rows of key_length characters,
// clamped to 1..MAX_KEY_CHARS. Registers (mode, key_length, key_chars_low,
// key_chars_high) are written through cfg_valid/cfg_index/cfg_data; cfg_ready
// is always high. Write them only while the unit is idle; each write rebuilds
// the rank table, key position by key position, before the next row can
// drain. Input: one item a cycle while a row slot is free; two slots are used
// in turn, so full rises only when both rows wait on the output side. Output:
// one character a cycle within a row while pop keeps the output register
// free; the final row in decrypt mode first scans back over up to key_length
// columns to trim its trailing pad. A completed row reaches the ports through
// its slot, the sequencer state and the output register. A stalled receiver
// holds the output register, then the row being drained, then the second
// slot; after that full rises. Reset clears the registers to their defaults,
// empties both slots and the output register.
// ----------------------------------------------------------------------------
module row_block_transposition_cipher_unit #(
	parameter int MAX_KEY_CHARS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [rbt_pkg::CHAR_W-1:0]    char_in,
	input  logic                          message_last,
	output logic                          empty,
	input  logic                          pop,
	output logic [rbt_pkg::CHAR_W-1:0]    char_out,
	output logic                          row_end,
	output logic                          message_end,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rbt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rbt_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W = $clog2(MAX_KEY_CHARS);
	localparam int CNT_W = $clog2(MAX_KEY_CHARS + 1);

	logic                           mode_q;
	logic [rbt_pkg::KEY_LEN_W-1:0]  key_length_q;
	logic [rbt_pkg::KEY_REG_W-1:0]  key_low_q;
	logic [rbt_pkg::KEY_REG_W-1:0]  key_high_q;
	logic                           cfg_we;
	logic [CNT_W-1:0]               len;

	logic                           wr_en;
	logic [IDX_W-1:0]               wr_idx;
	logic [rbt_pkg::CHAR_W-1:0]     wr_char;
	rbt_pkg::row_tag_t              row_push;
	logic [CNT_W-1:0]               push_fill;
	logic                           slot_full;
	rbt_pkg::row_tag_t              head;
	logic [CNT_W-1:0]               head_fill;
	logic [IDX_W-1:0]               rd_idx;
	logic [rbt_pkg::CHAR_W-1:0]     rd_char;
	logic                           release_row;
	logic                           tbl_ready;
	logic [IDX_W-1:0]               tbl_idx;
	logic [IDX_W-1:0]               tbl_src;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= 1'b0;
			key_length_q <= rbt_pkg::KEY_LEN_W'(1);
			key_low_q    <= '0;
			key_high_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				rbt_pkg::CFG_MODE:       mode_q       <= cfg_data[0];
				rbt_pkg::CFG_KEY_LENGTH: key_length_q <= cfg_data[rbt_pkg::KEY_LEN_W-1:0];
				rbt_pkg::CFG_KEY_LOW:    key_low_q    <= cfg_data;
				rbt_pkg::CFG_KEY_HIGH:   key_high_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (key_length_q == '0) begin
			len = CNT_W'(1);
		end else if (key_length_q > rbt_pkg::KEY_LEN_W'(MAX_KEY_CHARS)) begin
			len = CNT_W'(MAX_KEY_CHARS);
		end else begin
			len = key_length_q[CNT_W-1:0];
		end
	end

	rbt_front #(.MAX_KEY_CHARS(MAX_KEY_CHARS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.char_in      (char_in),
		.message_last (message_last),
		.len          (len),
		.slot_full    (slot_full),
		.wr_en        (wr_en),
		.wr_idx       (wr_idx),
		.wr_char      (wr_char),
		.row_push     (row_push),
		.push_fill    (push_fill)
	);

	rbt_rowq #(.MAX_KEY_CHARS(MAX_KEY_CHARS)) u_rowq (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_idx      (wr_idx),
		.wr_char     (wr_char),
		.row_push    (row_push),
		.push_fill   (push_fill),
		.slot_full   (slot_full),
		.head        (head),
		.head_fill   (head_fill),
		.rd_idx      (rd_idx),
		.rd_char     (rd_char),
		.release_row (release_row)
	);

	rbt_rank #(.MAX_KEY_CHARS(MAX_KEY_CHARS)) u_rank (
		.clk       (clk),
		.arst_n    (arst_n),
		.rebuild   (cfg_we),
		.mode      (mode_q),
		.len       (len),
		.key_chars ({key_high_q, key_low_q}),
		.rd_idx    (tbl_idx),
		.rd_src    (tbl_src),
		.ready     (tbl_ready)
	);

	rbt_back #(.MAX_KEY_CHARS(MAX_KEY_CHARS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.mode        (mode_q),
		.len         (len),
		.head        (head),
		.head_fill   (head_fill),
		.rd_char     (rd_char),
		.rd_idx      (rd_idx),
		.release_row (release_row),
		.tbl_ready   (tbl_ready),
		.tbl_idx     (tbl_idx),
		.tbl_src     (tbl_src),
		.empty       (empty),
		.pop         (pop),
		.char_out    (char_out),
		.row_end     (row_end),
		.message_end (message_end)
	);

endmodule

@@ bench/row_block_transposition_cipher_unit_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row block transposition cipher unit - scoreboard
// Watches the message, result and register channels. Keeps its own copy of
// the registers and of the partial row, works out the permuted letters for
// every item taken and compares each result taken with the oldest one due.
// ----------------------------------------------------------------------------
module row_block_transposition_cipher_unit_checker #(
	parameter int MAX_KEY_CHARS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  logic                            full,
	input  logic [rbt_pkg::CHAR_W-1:0]      char_in,
	input  logic                            message_last,
	input  logic                            empty,
	input  logic                            pop,
	input  logic [rbt_pkg::CHAR_W-1:0]      char_out,
	input  logic                            row_end,
	input  logic                            message_end,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [rbt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rbt_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                              mismatches,
	output int                              outstanding
);
	import rbt_pkg::*;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              row_end;
		logic              message_end;
	} cipher_char_t;

	logic                 decrypt_q;
	logic [KEY_LEN_W-1:0] key_len_q;
	logic [KEY_REG_W-1:0] key_low_q;
	logic [KEY_REG_W-1:0] key_high_q;
	logic [CHAR_W-1:0]    row_buf [MAX_KEY_CHARS];
	logic [KEY_LEN_W-1:0] fill_q;
	cipher_char_t         expected_chars [$];

	function automatic int unsigned row_len();
		int unsigned n;
		n = key_len_q;
		if (n < 1) n = 1;
		if (n > MAX_KEY_CHARS) n = MAX_KEY_CHARS;
		return n;
	endfunction

	function automatic logic [CHAR_W-1:0] key_at(int unsigned i);
		if (i < 8) return key_low_q[8*i +: 8];
		return key_high_q[8*(i-8) +: 8];
	endfunction

	task automatic report_mismatch(string what);
		mismatches++;
		$display("checker: %s", what);
	endtask

	task automatic queue_row(logic closing);
		logic [CHAR_W-1:0] perm [MAX_KEY_CHARS];
		int unsigned       len;
		int unsigned       rank;
		int unsigned       count;
		int unsigned       p;
		int unsigned       i;
		cipher_char_t      item;
		len = row_len();
		for (p = 0; p < len; p++) begin
			rank = 0;
			for (i = 0; i < len; i++) begin
				if (key_at(i) < key_at(p) || (key_at(i) == key_at(p) && i < p)) rank++;
			end
			if (decrypt_q) perm[rank] = row_buf[p];
			else perm[p] = row_buf[rank];
		end
		count = len;
		// drop trailing pad of the final row when deciphering
		if (closing && decrypt_q) begin
			while (count > 0 && perm[count-1] == PAD_CHAR) count--;
		end
		for (p = 0; p < count; p++) begin
			item.ch          = perm[p];
			item.row_end     = (p == count - 1);
			item.message_end = (p == count - 1) && closing;
			expected_chars   = {expected_chars, item};
		end
	endtask

	task automatic predict_item(logic [CHAR_W-1:0] raw, logic last);
		logic [CHAR_W-1:0] c;
		int unsigned       len;
		int unsigned       i;
		c   = raw;
		len = row_len();
		if (c >= LOWER_A && c <= LOWER_Z) c = c - CASE_OFFSET;
		if (c >= UPPER_A && c <= UPPER_Z) begin
			if (fill_q < MAX_KEY_CHARS) row_buf[fill_q] = c;
			fill_q = fill_q + 1'b1;
		end
		if (fill_q >= len || (last && fill_q != 0)) begin
			for (i = fill_q; i < len; i++) row_buf[i] = PAD_CHAR;
			queue_row(last);
			fill_q = '0;
		end
	endtask

	task automatic check_result();
		cipher_char_t want;
		if (expected_chars.size() == 0) begin
			report_mismatch($sformatf("result %02h with nothing predicted", char_out));
		end else begin
			want = expected_chars.pop_front();
			if (char_out !== want.ch)
				report_mismatch($sformatf("char_out %02h, predicted %02h", char_out, want.ch));
			if (row_end !== want.row_end)
				report_mismatch($sformatf("row_end %b, predicted %b on char %02h",
					row_end, want.row_end, want.ch));
			if (message_end !== want.message_end)
				report_mismatch($sformatf("message_end %b, predicted %b on char %02h",
					message_end, want.message_end, want.ch));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decrypt_q  = 1'b0;
			key_len_q  = KEY_LEN_W'(1);
			key_low_q  = '0;
			key_high_q = '0;
			fill_q     = '0;
			expected_chars.delete();
			outstanding = 0;
		end else begin
			if (pop && !empty) check_result();
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MODE:       decrypt_q  = cfg_data[0];
					CFG_KEY_LENGTH: key_len_q  = cfg_data[KEY_LEN_W-1:0];
					CFG_KEY_LOW:    key_low_q  = cfg_data;
					CFG_KEY_HIGH:   key_high_q = cfg_data;
					default: ;
				endcase
			end
			if (push && !full) predict_item(char_in, message_last);
			outstanding = expected_chars.size();
		end
	end

endmodule

@@ bench/row_block_transposition_cipher_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row block transposition cipher unit - testbench
// Drives message bytes and register writes into the unit and pops its
// results with random gaps on both sides, including one long output stall
// that backs the unit up. A directed opening covers character extremes,
// deciphering with pad trimming, an all-pad final row, a final byte with
// nothing pending and a row length lowered mid-row; random phases follow
// under varied keys, lengths and modes. A scoreboard beside the unit checks
// every result.
// ----------------------------------------------------------------------------
module row_block_transposition_cipher_unit_tb;
	import rbt_pkg::*;

	localparam int MAX_KEY_CHARS = 16;
	localparam int RESET_CYCLES  = 7;
	localparam int SETTLE_CYCLES = 48;
	localparam int STALL_LIMIT   = 2000;
	localparam int LONG_HOLD     = 300;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 40;
	localparam int FLOOD_ITEMS   = 44;
	localparam int TX_SIDE       = 0;
	localparam int RX_SIDE       = 1;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	logic [CHAR_W-1:0]     char_in;
	logic                  message_last;
	logic                  empty;
	logic                  pop;
	logic [CHAR_W-1:0]     char_out;
	logic                  row_end;
	logic                  message_end;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    outstanding;
	int                    hold_requests = 0;
	int                    stall_cycles  = 0;
	int unsigned           calm_left [2] = '{0, 0};

	always #4 clk = ~clk;

	row_block_transposition_cipher_unit #(.MAX_KEY_CHARS(MAX_KEY_CHARS)) dut (.*);

	row_block_transposition_cipher_unit_checker #(.MAX_KEY_CHARS(MAX_KEY_CHARS)) u_checker (.*);

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic int unsigned pick_gap(int side);
		int unsigned roll;
		if (calm_left[side] != 0) begin
			calm_left[side]--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 4) begin
			calm_left[side] = $urandom_range(20, 60);
			return 0;
		end
		if (roll < 55) return 0;
		if (roll < 88) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [CHAR_W-1:0] rand_char();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 40) return CHAR_W'($urandom_range(UPPER_A, UPPER_Z));
		if (roll < 70) return CHAR_W'($urandom_range(LOWER_A, LOWER_Z));
		if (roll < 76) return PAD_CHAR;
		if (roll < 82) return PAD_CHAR + CASE_OFFSET;
		return CHAR_W'($urandom);
	endfunction

	function automatic logic [KEY_REG_W-1:0] rand_key();
		logic [KEY_REG_W-1:0] k;
		int unsigned          roll;
		int                   b;
		roll = $urandom_range(0, 9);
		k = {$urandom, $urandom};
		if (roll == 0) k = '0;
		else if (roll == 1) k = '1;
		else if (roll < 5) begin
			for (b = 0; b < 8; b++) k[8*b +: 8] = UPPER_A + CHAR_W'($urandom_range(0, 2));
		end else if (roll < 7) begin
			for (b = 0; b < 8; b++) k[8*b +: 8] = CHAR_W'($urandom_range(UPPER_A, UPPER_Z));
		end
		return k;
	endfunction

	function automatic logic [KEY_LEN_W-1:0] rand_len();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		case (roll)
			0: return KEY_LEN_W'(0);
			1: return KEY_LEN_W'(1);
			2: return KEY_LEN_W'(16);
			3: return KEY_LEN_W'($urandom_range(17, 31));
			default: return KEY_LEN_W'($urandom_range(2, 16));
		endcase
	endfunction

	task automatic send_item(logic [CHAR_W-1:0] c, logic last);
		int unsigned gap;
		gap = pick_gap(TX_SIDE);
		if (gap != 0) begin
			push    <= 1'b0;
			char_in <= CHAR_W'($urandom);
			repeat (gap) @(negedge clk);
		end
		push         <= 1'b1;
		char_in      <= c;
		message_last <= last;
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	task automatic send_text(string s, logic last_at_end);
		int i;
		for (i = 0; i < s.len(); i++) send_item(s[i], last_at_end && (i == s.len() - 1));
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure(logic decrypt, logic [KEY_LEN_W-1:0] len,
			logic [KEY_REG_W-1:0] key_low, logic [KEY_REG_W-1:0] key_high);
		write_reg(CFG_MODE, CFG_DATA_W'(decrypt));
		write_reg(CFG_KEY_LENGTH, CFG_DATA_W'(len));
		write_reg(CFG_KEY_LOW, key_low);
		write_reg(CFG_KEY_HIGH, key_high);
	endtask

	task automatic wait_idle();
		push         <= 1'b0;
		message_last <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin : receiver
		int unsigned gap;
		int          hold_seen;
		gap       = 0;
		hold_seen = 0;
		pop       = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests != hold_seen) begin
				hold_seen = hold_requests;
				gap       = LONG_HOLD;
			end
			if (gap != 0) begin
				pop <= 1'b0;
				gap--;
			end else begin
				pop <= 1'b1;
				gap = pick_gap(RX_SIDE);
			end
		end
	end

	initial begin : stimulus
		int ph;
		int n;
		arst_n       = 1'b0;
		push         = 1'b0;
		char_in      = '0;
		message_last = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_MODE;
		cfg_data     = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// one-letter rows at reset defaults; non-letters around both letter ranges
		send_text("azAZ", 1'b0);
		send_item(8'h40, 1'b0);
		send_item(8'h5B, 1'b0);
		send_item(8'h60, 1'b0);
		send_item(8'h7B, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b1);

		// decipher with repeated and extreme key bytes; trim pad, then an all-pad row
		wait_idle();
		configure(1'b1, KEY_LEN_W'(5), 64'h4567_8942_0051_FF51, '1);
		send_text("HELLOwxx", 1'b1);
		send_text("xX", 1'b1);

		// lower the row length while letters wait
		wait_idle();
		configure(1'b0, KEY_LEN_W'(8), rand_key(), '0);
		send_text("abcde", 1'b0);
		wait_idle();
		write_reg(CFG_KEY_LENGTH, CFG_DATA_W'(3));
		send_item("f", 1'b0);

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_idle();
			configure(ph[0], (ph == 0) ? KEY_LEN_W'(31) : (ph == 1) ? KEY_LEN_W'(0) : rand_len(),
				rand_key(), rand_key());
			for (n = 0; n < PHASE_ITEMS; n++)
				send_item(rand_char(), 1'($urandom_range(0, 11) == 0));
		end

		// stall the output side while full rows keep coming
		wait_idle();
		configure(1'($urandom_range(0, 1)), KEY_LEN_W'(16), rand_key(), rand_key());
		hold_requests++;
		for (n = 0; n < FLOOD_ITEMS; n++)
			send_item(CHAR_W'($urandom_range(UPPER_A, UPPER_Z)), n == FLOOD_ITEMS - 1);

		wait_idle();
		if (outstanding != 0) $display("tb: %0d predicted characters never arrived", outstanding);
		if (mismatches == 0 && outstanding == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/rbt_pkg.sv
rtl/rbt_front.sv
rtl/rbt_rowq.sv
rtl/rbt_rank.sv
rtl/rbt_back.sv
rtl/row_block_transposition_cipher_unit.sv
bench/row_block_transposition_cipher_unit_checker.sv
bench/row_block_transposition_cipher_unit_tb.sv
